@@ sv/sfl_pkg.sv @@
// Shared types and constants for the segregated free-list allocator.
// No dependencies.
package sfl_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC_EXACT = 2'd0,
    OP_ALLOC_CHUNK = 2'd1,
    OP_INSERT      = 2'd2,
    OP_CLEAR       = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_ZERO    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_CLEARH,
    S_HEAD_RD,
    S_HEAD_WT,
    S_NODE_WT,
    S_NODE_CHK,
    S_UNLINK,
    S_SPLIT,
    S_PUSH,
    S_DONE
  } state_t;

  localparam int unsigned POOL_CELLS    = 4096;
  localparam int unsigned EXACT_CLASSES = 15;
  localparam int unsigned FIRST_EXP_LOG = 4;

  localparam int unsigned HEAD_SLOTS = 64;

endpackage

@@ sv/segregated_free_list_allocator_top.sv @@
// Top level of the segregated free-list allocator: control sequencer and the
// head, link and length memories. Depends on sfl_pkg and sfl_class.
//
// One item at a time: busy is high from start until the result strobe. After
// reset the block clears the class head memory, one entry a cycle, before
// taking items. An insert reads the head and pushes the block; a clear writes
// every head entry. Allocations pass the head read and head wait states for
// each class head visited and the node wait and node check states for each
// list position checked through the single-port node memories, the end of a
// list included; a hit then passes unlink, plus split and push when a split
// tail is pushed back, before the strobe. Results cannot be stalled.
module segregated_free_list_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [12:0] in_request_cells,
  input  logic [11:0] in_free_offset,
  input  logic [12:0] in_free_cells,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [11:0] out_block_offset,
  output logic [12:0] out_block_cells
);

  localparam int unsigned POOL_CELLS    = sfl_pkg::POOL_CELLS;
  localparam int unsigned EXACT_CLASSES = sfl_pkg::EXACT_CLASSES;
  localparam int unsigned FIRST_EXP_LOG = sfl_pkg::FIRST_EXP_LOG;
  localparam int unsigned AW = $clog2(POOL_CELLS);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned HW = 6;
  localparam int unsigned P2 = 1 << $clog2(POOL_CELLS);
  localparam int unsigned LG = $clog2(P2 >> 2);
  localparam int unsigned EXPC = (LG > FIRST_EXP_LOG) ? (LG - FIRST_EXP_LOG) * 2 : 0;
  localparam int unsigned NC0 = EXACT_CLASSES + EXPC + 1;
  localparam int unsigned NCLS = (NC0 > EXACT_CLASSES + 40) ? EXACT_CLASSES + 40 : NC0;
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_CELLS);

  logic [LW-1:0] head_mem [sfl_pkg::HEAD_SLOTS];
  logic [LW-1:0] link_mem [POOL_CELLS];
  logic [LW-1:0] len_mem  [POOL_CELLS];

  sfl_pkg::state_t st_r, st_nxt;
  logic [1:0]    op_r;
  logic [LW-1:0] req_r, len_r, off_r, cur_r, prev_r, steps_r, nlink_r;
  logic [HW-1:0] cls_r, lo_r;
  logic [1:0]    stat_r;
  logic [AW-1:0] rout_off_r;
  logic [LW-1:0] rout_len_r;
  logic          split_r;

  logic [LW-1:0] head_rd_r, link_rd_r, len_rd_r;
  logic          h_we;
  logic [HW-1:0] h_addr;
  logic [LW-1:0] h_wd;
  logic [AW-1:0] n_addr;
  logic          n_wlink, n_wlen;
  logic [LW-1:0] n_wd_link, n_wd_len;

  logic          at_end, fits, more_cls;

  logic [12:0] cls_in;
  logic [HW-1:0] cls_out;
  sfl_class #(.CW(13), .HW(HW), .EXACT_CLASSES(EXACT_CLASSES),
    .FIRST_EXP_LOG(FIRST_EXP_LOG), .TOP_CLASS(NCLS - 1)) u_cls (
    .cells(cls_in), .cls(cls_out));

  always_ff @(posedge clk) begin
    if (h_we) head_mem[h_addr] <= h_wd;
    head_rd_r <= head_mem[h_addr];
  end

  always_ff @(posedge clk) begin
    if (n_wlink) link_mem[n_addr] <= n_wd_link;
    if (n_wlen) len_mem[n_addr] <= n_wd_len;
    link_rd_r <= link_mem[n_addr];
    len_rd_r  <= len_mem[n_addr];
  end

  assign busy = (st_r != sfl_pkg::S_IDLE);
  assign cls_in = (st_r == sfl_pkg::S_IDLE) ? in_request_cells : 13'(len_r);

  // Node check decisions, shared by next-state and datapath.
  always_comb begin
    at_end = (cur_r >= NULL_LINK) || (steps_r == LW'(POOL_CELLS));
    fits = (len_rd_r >= req_r);
    more_cls = (op_r == sfl_pkg::OP_ALLOC_EXACT) ? (cls_r != HW'(NCLS - 1))
                                                 : (cls_r != lo_r);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      sfl_pkg::S_IDLE:     if (start) st_nxt = sfl_pkg::S_HEAD_RD;
      sfl_pkg::S_INIT:
        if (cls_r == HW'(sfl_pkg::HEAD_SLOTS - 1)) st_nxt = sfl_pkg::S_IDLE;
      sfl_pkg::S_CLEARH:
        if (cls_r == HW'(sfl_pkg::HEAD_SLOTS - 1)) st_nxt = sfl_pkg::S_DONE;
      sfl_pkg::S_HEAD_RD: begin
        if (stat_r != sfl_pkg::ST_OK) st_nxt = sfl_pkg::S_DONE;
        else if (op_r == sfl_pkg::OP_CLEAR) st_nxt = sfl_pkg::S_CLEARH;
        else if (op_r == sfl_pkg::OP_INSERT) st_nxt = sfl_pkg::S_PUSH;
        else st_nxt = sfl_pkg::S_HEAD_WT;
      end
      sfl_pkg::S_HEAD_WT:  st_nxt = sfl_pkg::S_NODE_WT;
      sfl_pkg::S_NODE_WT:  st_nxt = sfl_pkg::S_NODE_CHK;
      sfl_pkg::S_NODE_CHK: begin
        if (at_end) st_nxt = more_cls ? sfl_pkg::S_HEAD_RD : sfl_pkg::S_DONE;
        else if (fits) st_nxt = sfl_pkg::S_UNLINK;
        else st_nxt = sfl_pkg::S_NODE_WT;
      end
      sfl_pkg::S_UNLINK:   st_nxt = split_r ? sfl_pkg::S_SPLIT : sfl_pkg::S_DONE;
      sfl_pkg::S_SPLIT:    st_nxt = sfl_pkg::S_PUSH;
      sfl_pkg::S_PUSH:     st_nxt = sfl_pkg::S_DONE;
      sfl_pkg::S_DONE:     st_nxt = sfl_pkg::S_IDLE;
      default:             st_nxt = sfl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    h_we = 1'b0; h_addr = cls_r; h_wd = NULL_LINK;
    n_wlink = 1'b0; n_wlen = 1'b0; n_addr = cur_r[AW-1:0];
    n_wd_link = head_rd_r; n_wd_len = len_r;
    unique case (st_r)
      sfl_pkg::S_INIT: h_we = 1'b1;
      sfl_pkg::S_CLEARH: h_we = 1'b1;
      sfl_pkg::S_HEAD_RD: h_addr = (op_r == sfl_pkg::OP_INSERT) ? cls_out : cls_r;
      sfl_pkg::S_NODE_WT: n_addr = cur_r[AW-1:0];
      sfl_pkg::S_NODE_CHK: n_addr = at_end ? cur_r[AW-1:0] : link_rd_r[AW-1:0];
      sfl_pkg::S_UNLINK: begin
        if (prev_r == NULL_LINK) begin
          h_we = 1'b1; h_wd = nlink_r;
        end else begin
          n_wlink = 1'b1; n_addr = prev_r[AW-1:0]; n_wd_link = nlink_r;
        end
      end
      sfl_pkg::S_SPLIT: h_addr = cls_out;
      sfl_pkg::S_PUSH: begin
        h_addr = cls_r;
        h_we = 1'b1; h_wd = off_r;
        n_wlink = 1'b1; n_wlen = 1'b1; n_addr = off_r[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sfl_pkg::S_INIT;
      cls_r <= '0;
      op_r <= sfl_pkg::OP_CLEAR;
      stat_r <= sfl_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (st_r == sfl_pkg::S_DONE);
      st_r <= st_nxt;
      unique case (st_r)
        sfl_pkg::S_IDLE: if (start) begin
          op_r <= in_opcode;
          req_r <= LW'(in_request_cells);
          split_r <= 1'b0;
          rout_off_r <= '0; rout_len_r <= '0;
          prev_r <= NULL_LINK; steps_r <= '0;
          if (in_opcode == sfl_pkg::OP_INSERT) begin
            off_r <= LW'(in_free_offset);
            if ({1'b0, in_free_offset} >= 13'(POOL_CELLS)) begin
              stat_r <= sfl_pkg::ST_ZERO;
            end else if (in_free_cells > 13'(POOL_CELLS) - {1'b0, in_free_offset}) begin
              stat_r <= sfl_pkg::ST_OK;
              len_r <= LW'(13'(POOL_CELLS) - {1'b0, in_free_offset});
            end else begin
              stat_r <= (in_free_cells == '0) ? sfl_pkg::ST_ZERO : sfl_pkg::ST_OK;
              len_r <= LW'(in_free_cells);
            end
          end else if (in_opcode == sfl_pkg::OP_CLEAR) begin
            stat_r <= sfl_pkg::ST_OK;
            cls_r <= '0;
          end else begin
            stat_r <= (in_request_cells == '0) ? sfl_pkg::ST_ZERO : sfl_pkg::ST_OK;
            lo_r <= cls_out;
            cls_r <= (in_opcode == sfl_pkg::OP_ALLOC_EXACT) ? cls_out : HW'(NCLS - 1);
          end
        end
        sfl_pkg::S_HEAD_RD: if (op_r == sfl_pkg::OP_INSERT) begin
          cls_r <= cls_out;
        end
        sfl_pkg::S_INIT: cls_r <= cls_r + HW'(1);
        sfl_pkg::S_CLEARH: cls_r <= cls_r + HW'(1);
        sfl_pkg::S_HEAD_WT: begin
          cur_r <= head_rd_r; prev_r <= NULL_LINK; steps_r <= '0;
        end
        sfl_pkg::S_NODE_CHK: begin
          if (at_end) begin
            if (more_cls) begin
              cls_r <= (op_r == sfl_pkg::OP_ALLOC_EXACT) ? cls_r + HW'(1) : cls_r - HW'(1);
            end else begin
              stat_r <= sfl_pkg::ST_NO_FIT;
            end
          end else if (fits) begin
            nlink_r <= link_rd_r;
            rout_off_r <= cur_r[AW-1:0];
            off_r <= cur_r + req_r;
            len_r <= len_rd_r - req_r;
            if (op_r == sfl_pkg::OP_ALLOC_EXACT) begin
              rout_len_r <= req_r;
              split_r <= (len_rd_r > req_r);
            end else begin
              rout_len_r <= len_rd_r;
            end
          end else begin
            prev_r <= cur_r;
            cur_r <= link_rd_r;
            steps_r <= steps_r + LW'(1);
          end
        end
        sfl_pkg::S_SPLIT: cls_r <= cls_out;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == sfl_pkg::S_DONE) begin
      out_status <= stat_r;
      out_block_offset <= (stat_r == sfl_pkg::ST_OK) ? 12'(rout_off_r) : '0;
      out_block_cells <= (stat_r == sfl_pkg::ST_OK) ? 13'(rout_len_r) : '0;
    end
  end

endmodule

@@ sv/sfl_class.sv @@
// Size class mapping: cell count to class index.
// No dependencies.
module sfl_class #(
  parameter int unsigned CW = 13,
  parameter int unsigned HW = 6,
  parameter int unsigned EXACT_CLASSES = 15,
  parameter int unsigned FIRST_EXP_LOG = 4,
  parameter int unsigned TOP_CLASS = 34
) (
  input  logic [CW-1:0] cells,
  output logic [HW-1:0] cls
);

  localparam int unsigned LGW = $clog2(CW);

  logic [LGW-1:0] lg;
  logic [CW+6:0]  idx;

  always_comb begin
    lg = '0;
    for (int i = 0; i < CW; i++) begin
      if (cells[i]) lg = LGW'(i);
    end
    idx = '0;
    if (lg >= LGW'(FIRST_EXP_LOG)) begin
      idx = (CW+7)'((lg - LGW'(FIRST_EXP_LOG)) * 2);
      if (lg != '0 && cells[lg - LGW'(1)]) idx = idx + (CW+7)'(1);
    end
    idx = idx + (CW+7)'(EXACT_CLASSES);
    if (cells <= CW'(EXACT_CLASSES)) begin
      cls = HW'(cells - CW'(1));
    end else if (idx < (CW+7)'(TOP_CLASS)) begin
      cls = HW'(idx);
    end else begin
      cls = HW'(TOP_CLASS);
    end
  end

endmodule

@@ sv/sfl_checker.sv @@
// Port-level checker for the allocator, bound to the top level.
// Depends on sfl_pkg.
module sfl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [11:0] out_block_offset,
  input logic [12:0] out_block_cells
);

  a_no_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(out_valid)) else $error("double strobe");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != sfl_pkg::ST_OK) |->
      (out_block_offset == '0 && out_block_cells == '0)) else $error("failure payload");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3)) else $error("bad status");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("not busy after start");

endmodule

bind segregated_free_list_allocator_top sfl_checker u_chk (.*);
